// ===== hw/rtl/sspd_pkg.sv =====
// Shared types and constants for the sync/sweep pulse decoder.
// Holds the configuration record, register indexes and axis codes.
// No dependencies.
`default_nettype none

package sspd_pkg;

	localparam int US_WIDTH    = 20;
	localparam int COUNT_WIDTH = 4;
	localparam int TICK_WIDTH  = 4;
	localparam int AXIS_WIDTH  = 2;
	localparam int ADDR_WIDTH  = 5;
	localparam int DATA_WIDTH  = 32;
	localparam int INDEX_WIDTH = 3;

	localparam logic [US_WIDTH-1:0] US_MAX = '1;

	// Register indexes, one word apart on the configuration bus.
	localparam logic [INDEX_WIDTH-1:0] REG_US_PER_TICK      = 3'd0;
	localparam logic [INDEX_WIDTH-1:0] REG_SYNC_WIDTH_MIN   = 3'd1;
	localparam logic [INDEX_WIDTH-1:0] REG_SWEEP_WIDTH_LOW  = 3'd2;
	localparam logic [INDEX_WIDTH-1:0] REG_SWEEP_WIDTH_HIGH = 3'd3;
	localparam logic [INDEX_WIDTH-1:0] REG_SYNC_COUNT_LIMIT = 3'd4;
	localparam logic [INDEX_WIDTH-1:0] REG_X_SYNC_COUNT     = 3'd5;
	localparam logic [INDEX_WIDTH-1:0] REG_Y_SYNC_COUNT     = 3'd6;

	// Reset values of the registers.
	localparam logic [TICK_WIDTH-1:0]  RST_US_PER_TICK      = 4'd4;
	localparam logic [US_WIDTH-1:0]    RST_SYNC_WIDTH_MIN   = 20'd70;
	localparam logic [US_WIDTH-1:0]    RST_SWEEP_WIDTH_LOW  = 20'd3;
	localparam logic [US_WIDTH-1:0]    RST_SWEEP_WIDTH_HIGH = 20'd20;
	localparam logic [COUNT_WIDTH-1:0] RST_SYNC_COUNT_LIMIT = 4'd10;
	localparam logic [COUNT_WIDTH-1:0] RST_X_SYNC_COUNT     = 4'd3;
	localparam logic [COUNT_WIDTH-1:0] RST_Y_SYNC_COUNT     = 4'd1;

	// Codes of the sweep_axis field.
	localparam logic [AXIS_WIDTH-1:0] AXIS_NONE = 2'd0;
	localparam logic [AXIS_WIDTH-1:0] AXIS_X    = 2'd1;
	localparam logic [AXIS_WIDTH-1:0] AXIS_Y    = 2'd2;

	typedef struct packed {
		logic [TICK_WIDTH-1:0]  us_per_tick;
		logic [US_WIDTH-1:0]    sync_width_min;
		logic [US_WIDTH-1:0]    sweep_width_low;
		logic [US_WIDTH-1:0]    sweep_width_high;
		logic [COUNT_WIDTH-1:0] sync_count_limit;
		logic [COUNT_WIDTH-1:0] x_sync_count;
		logic [COUNT_WIDTH-1:0] y_sync_count;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sync_sweep_pulse_decoder_unit.sv =====
// Sync/sweep pulse decoder, top level: configuration registers and datapath.
// Path: input register, then result register, then the output channel.
// Throughput: one transaction per cycle, set by the single-pass datapath,
// while out_ready does not stall the output.
// Reset: arst_n loads the register defaults and clears all decoder state.
// Depends on sspd_pkg, sspd_regs and sspd_core.
`default_nettype none

module sync_sweep_pulse_decoder_unit
	import sspd_pkg::*;
#(
	parameter int STAMP_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_WIDTH-1:0]  paddr,
	input  wire logic [DATA_WIDTH-1:0]  pwdata,
	output logic      [DATA_WIDTH-1:0]  prdata,
	output logic                        pready,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [STAMP_WIDTH-1:0] rise_time,
	input  wire logic [STAMP_WIDTH-1:0] fall_time,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [US_WIDTH-1:0]    pulse_width_us,
	output logic      [COUNT_WIDTH-1:0] sync_count,
	output logic      [AXIS_WIDTH-1:0]  sweep_axis,
	output logic                        pair_ready,
	output logic      [US_WIDTH-1:0]    x_interval_us,
	output logic      [US_WIDTH-1:0]    y_interval_us
);

	cfg_t cfg;

	sspd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sspd_core #(.STAMP_WIDTH(STAMP_WIDTH)) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rise_time      (rise_time),
		.fall_time      (fall_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pulse_width_us (pulse_width_us),
		.sync_count     (sync_count),
		.sweep_axis     (sweep_axis),
		.pair_ready     (pair_ready),
		.x_interval_us  (x_interval_us),
		.y_interval_us  (y_interval_us)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/sspd_scale.sv =====
// Wrapping stamp difference scaled to microseconds and saturated to 20 bits.
// Depends on sspd_pkg.
`default_nettype none

module sspd_scale
	import sspd_pkg::*;
#(
	parameter int STAMP_WIDTH = 16
) (
	input  wire logic [STAMP_WIDTH-1:0] later,
	input  wire logic [STAMP_WIDTH-1:0] earlier,
	input  wire logic [TICK_WIDTH-1:0]  us_per_tick,
	output logic      [US_WIDTH-1:0]    scaled
);

	localparam int PW = STAMP_WIDTH + TICK_WIDTH;
	localparam int EW = (PW > US_WIDTH) ? PW : US_WIDTH;

	logic [STAMP_WIDTH-1:0] diff;
	logic [PW-1:0]          prod;
	logic [EW-1:0]          prod_ext;

	assign diff     = later - earlier;
	assign prod     = PW'(diff) * PW'(us_per_tick);
	assign prod_ext = EW'(prod);
	assign scaled   = (prod_ext > EW'(US_MAX)) ? US_MAX : prod_ext[US_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/sspd_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on sspd_pkg.
`default_nettype none

module sspd_regs
	import sspd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_WIDTH-1:0] paddr,
	input  wire logic [DATA_WIDTH-1:0] pwdata,
	output logic      [DATA_WIDTH-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t                   cfg_q;
	logic [INDEX_WIDTH-1:0] index;
	logic                   wr_en;

	assign index  = paddr[ADDR_WIDTH-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.us_per_tick      <= RST_US_PER_TICK;
			cfg_q.sync_width_min   <= RST_SYNC_WIDTH_MIN;
			cfg_q.sweep_width_low  <= RST_SWEEP_WIDTH_LOW;
			cfg_q.sweep_width_high <= RST_SWEEP_WIDTH_HIGH;
			cfg_q.sync_count_limit <= RST_SYNC_COUNT_LIMIT;
			cfg_q.x_sync_count     <= RST_X_SYNC_COUNT;
			cfg_q.y_sync_count     <= RST_Y_SYNC_COUNT;
		end else if (wr_en) begin
			unique case (index)
				REG_US_PER_TICK:      cfg_q.us_per_tick      <= pwdata[TICK_WIDTH-1:0];
				REG_SYNC_WIDTH_MIN:   cfg_q.sync_width_min   <= pwdata[US_WIDTH-1:0];
				REG_SWEEP_WIDTH_LOW:  cfg_q.sweep_width_low  <= pwdata[US_WIDTH-1:0];
				REG_SWEEP_WIDTH_HIGH: cfg_q.sweep_width_high <= pwdata[US_WIDTH-1:0];
				REG_SYNC_COUNT_LIMIT: cfg_q.sync_count_limit <= pwdata[COUNT_WIDTH-1:0];
				REG_X_SYNC_COUNT:     cfg_q.x_sync_count     <= pwdata[COUNT_WIDTH-1:0];
				REG_Y_SYNC_COUNT:     cfg_q.y_sync_count     <= pwdata[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			REG_US_PER_TICK:      prdata = DATA_WIDTH'(cfg_q.us_per_tick);
			REG_SYNC_WIDTH_MIN:   prdata = DATA_WIDTH'(cfg_q.sync_width_min);
			REG_SWEEP_WIDTH_LOW:  prdata = DATA_WIDTH'(cfg_q.sweep_width_low);
			REG_SWEEP_WIDTH_HIGH: prdata = DATA_WIDTH'(cfg_q.sweep_width_high);
			REG_SYNC_COUNT_LIMIT: prdata = DATA_WIDTH'(cfg_q.sync_count_limit);
			REG_X_SYNC_COUNT:     prdata = DATA_WIDTH'(cfg_q.x_sync_count);
			REG_Y_SYNC_COUNT:     prdata = DATA_WIDTH'(cfg_q.y_sync_count);
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sspd_core.sv =====
// Decoder datapath: input register, one pass of pulse classification and
// axis capture, decoder state and result register.
// Depends on sspd_pkg and sspd_scale.
`default_nettype none

module sspd_core
	import sspd_pkg::*;
#(
	parameter int STAMP_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [STAMP_WIDTH-1:0] rise_time,
	input  wire logic [STAMP_WIDTH-1:0] fall_time,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [US_WIDTH-1:0]    pulse_width_us,
	output logic      [COUNT_WIDTH-1:0] sync_count,
	output logic      [AXIS_WIDTH-1:0]  sweep_axis,
	output logic                        pair_ready,
	output logic      [US_WIDTH-1:0]    x_interval_us,
	output logic      [US_WIDTH-1:0]    y_interval_us
);

	// Input stage.
	logic                   valid_s1;
	logic [STAMP_WIDTH-1:0] rise_s1;
	logic [STAMP_WIDTH-1:0] fall_s1;

	// Decoder state.
	logic [COUNT_WIDTH-1:0] sync_counter_q;
	logic [STAMP_WIDTH-1:0] last_sync_fall_q;
	logic                   x_seen_q;
	logic                   y_seen_q;
	logic [US_WIDTH-1:0]    x_time_q;
	logic [US_WIDTH-1:0]    y_time_q;

	// Result stage.
	logic                   valid_s2;
	logic [US_WIDTH-1:0]    width_s2;
	logic [COUNT_WIDTH-1:0] count_s2;
	logic [AXIS_WIDTH-1:0]  axis_s2;
	logic                   pair_s2;
	logic [US_WIDTH-1:0]    x_ival_s2;
	logic [US_WIDTH-1:0]    y_ival_s2;

	logic                   advance;
	logic [US_WIDTH-1:0]    width;
	logic [US_WIDTH-1:0]    since_sync;
	logic [US_WIDTH-1:0]    interval;
	logic [COUNT_WIDTH-1:0] count_start;
	logic [COUNT_WIDTH-1:0] count_synced;
	logic [COUNT_WIDTH-1:0] count_next;
	logic                   is_sync;
	logic                   is_sweep;
	logic                   x_hit;
	logic                   y_hit;
	logic                   x_seen_next;
	logic                   y_seen_next;
	logic                   pair;
	logic [US_WIDTH-1:0]    x_time_next;
	logic [US_WIDTH-1:0]    y_time_next;
	logic [AXIS_WIDTH-1:0]  axis;

	// The result register is free, or is emptied in this cycle.
	assign advance  = ~valid_s2 | out_ready;
	assign in_ready = ~valid_s1 | advance;

	sspd_scale #(.STAMP_WIDTH(STAMP_WIDTH)) u_width (
		.later       (fall_s1),
		.earlier     (rise_s1),
		.us_per_tick (cfg.us_per_tick),
		.scaled      (width)
	);

	sspd_scale #(.STAMP_WIDTH(STAMP_WIDTH)) u_interval (
		.later       (fall_s1),
		.earlier     (last_sync_fall_q),
		.us_per_tick (cfg.us_per_tick),
		.scaled      (since_sync)
	);

	always_comb begin
		count_start  = (sync_counter_q > cfg.sync_count_limit) ? '0 : sync_counter_q;
		is_sync      = width > cfg.sync_width_min;
		count_synced = is_sync ? COUNT_WIDTH'(count_start + 1'b1) : count_start;
		// A sync pulse moves the reference edge onto its own falling stamp,
		// so an interval measured in the same transaction is zero.
		interval     = is_sync ? '0 : since_sync;
		is_sweep     = (width < cfg.sweep_width_high) && (width > cfg.sweep_width_low);
		x_hit        = is_sweep && (count_synced == cfg.x_sync_count);
		y_hit        = is_sweep && !x_hit && (count_synced == cfg.y_sync_count);
		count_next   = (x_hit || y_hit) ? '0 : count_synced;
		x_seen_next  = x_seen_q | x_hit;
		y_seen_next  = y_seen_q | y_hit;
		pair         = x_seen_next & y_seen_next;
		x_time_next  = x_hit ? interval : x_time_q;
		y_time_next  = y_hit ? interval : y_time_q;
		if (x_hit) begin
			axis = AXIS_X;
		end else if (y_hit) begin
			axis = AXIS_Y;
		end else begin
			axis = AXIS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rise_s1 <= rise_time;
			fall_s1 <= fall_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_counter_q   <= '0;
			last_sync_fall_q <= '0;
			x_seen_q         <= 1'b0;
			y_seen_q         <= 1'b0;
			x_time_q         <= '0;
			y_time_q         <= '0;
			valid_s2         <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				sync_counter_q <= count_next;
				if (is_sync) begin
					last_sync_fall_q <= fall_s1;
				end
				x_seen_q <= x_seen_next & ~pair;
				y_seen_q <= y_seen_next & ~pair;
				x_time_q <= x_time_next;
				y_time_q <= y_time_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			width_s2  <= width;
			count_s2  <= count_next;
			axis_s2   <= axis;
			pair_s2   <= pair;
			x_ival_s2 <= pair ? x_time_next : '0;
			y_ival_s2 <= pair ? y_time_next : '0;
		end
	end

	assign out_valid      = valid_s2;
	assign pulse_width_us = width_s2;
	assign sync_count     = count_s2;
	assign sweep_axis     = axis_s2;
	assign pair_ready     = pair_s2;
	assign x_interval_us  = x_ival_s2;
	assign y_interval_us  = y_ival_s2;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sync_sweep_pulse_decoder_unit: directed and random pulses
// checked against a scoreboard that decodes them independently. Needs sspd_pkg and the RTL.

module testbench;
	import sspd_pkg::*;

	typedef struct packed {
		logic [US_WIDTH-1:0]    width;
		logic [COUNT_WIDTH-1:0] count;
		logic [AXIS_WIDTH-1:0]  axis;
		logic                   pair;
		logic [US_WIDTH-1:0]    x_iv;
		logic [US_WIDTH-1:0]    y_iv;
	} pulse_fields_t;

	class pulse_decode_scoreboard;
		cfg_t                   cfg;
		logic [COUNT_WIDTH-1:0] sync_ctr;
		logic [15:0]            last_sync_fall;
		bit                     x_seen;
		bit                     y_seen;
		logic [US_WIDTH-1:0]    x_time;
		logic [US_WIDTH-1:0]    y_time;
		pulse_fields_t          pending_results[$];
		int                     mismatches;

		function new();
			cfg.us_per_tick      = RST_US_PER_TICK;
			cfg.sync_width_min   = RST_SYNC_WIDTH_MIN;
			cfg.sweep_width_low  = RST_SWEEP_WIDTH_LOW;
			cfg.sweep_width_high = RST_SWEEP_WIDTH_HIGH;
			cfg.sync_count_limit = RST_SYNC_COUNT_LIMIT;
			cfg.x_sync_count     = RST_X_SYNC_COUNT;
			cfg.y_sync_count     = RST_Y_SYNC_COUNT;
			sync_ctr       = '0;
			last_sync_fall = '0;
			x_seen         = 1'b0;
			y_seen         = 1'b0;
			x_time         = '0;
			y_time         = '0;
			mismatches     = 0;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void write_reg(logic [INDEX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] value);
			case (idx)
				REG_US_PER_TICK:      cfg.us_per_tick      = value[TICK_WIDTH-1:0];
				REG_SYNC_WIDTH_MIN:   cfg.sync_width_min   = value[US_WIDTH-1:0];
				REG_SWEEP_WIDTH_LOW:  cfg.sweep_width_low  = value[US_WIDTH-1:0];
				REG_SWEEP_WIDTH_HIGH: cfg.sweep_width_high = value[US_WIDTH-1:0];
				REG_SYNC_COUNT_LIMIT: cfg.sync_count_limit = value[COUNT_WIDTH-1:0];
				REG_X_SYNC_COUNT:     cfg.x_sync_count     = value[COUNT_WIDTH-1:0];
				REG_Y_SYNC_COUNT:     cfg.y_sync_count     = value[COUNT_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		// Wrapping stamp difference in microseconds, clipped to the 20-bit field.
		function logic [US_WIDTH-1:0] scale_ticks(logic [15:0] later, logic [15:0] earlier);
			logic [15:0] ticks;
			logic [35:0] us;
			ticks = later - earlier;
			us = 36'(ticks) * 36'(cfg.us_per_tick);
			return (us > 36'(US_MAX)) ? US_MAX : us[US_WIDTH-1:0];
		endfunction

		function void note_pulse(logic [15:0] rise, logic [15:0] fall);
			pulse_fields_t r;
			r = '0;
			r.axis = AXIS_NONE;
			if (sync_ctr > cfg.sync_count_limit)
				sync_ctr = '0;
			r.width = scale_ticks(fall, rise);
			if (r.width > cfg.sync_width_min) begin
				sync_ctr = sync_ctr + 1'b1;
				last_sync_fall = fall;
			end
			// A pulse may qualify as both sync and sweep; the sync update comes first.
			if (r.width < cfg.sweep_width_high && r.width > cfg.sweep_width_low) begin
				if (sync_ctr == cfg.x_sync_count) begin
					x_seen = 1'b1;
					x_time = scale_ticks(fall, last_sync_fall);
					sync_ctr = '0;
					r.axis = AXIS_X;
				end else if (sync_ctr == cfg.y_sync_count) begin
					y_seen = 1'b1;
					y_time = scale_ticks(fall, last_sync_fall);
					sync_ctr = '0;
					r.axis = AXIS_Y;
				end
			end
			r.count = sync_ctr;
			if (x_seen && y_seen) begin
				r.pair = 1'b1;
				r.x_iv = x_time;
				r.y_iv = y_time;
				x_seen = 1'b0;
				y_seen = 1'b0;
			end
			pending_results.push_back(r);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction

		function void compare(string field, logic [US_WIDTH-1:0] want, logic [US_WIDTH-1:0] got);
			if (got !== want)
				report($sformatf("%s expected %0d, got %0d", field, want, got));
		endfunction

		function void check_result(pulse_fields_t got);
			pulse_fields_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing pending, pulse_width_us %0d", got.width));
				return;
			end
			want = pending_results.pop_front();
			compare("pulse_width_us", want.width, got.width);
			compare("sync_count", US_WIDTH'(want.count), US_WIDTH'(got.count));
			compare("sweep_axis", US_WIDTH'(want.axis), US_WIDTH'(got.axis));
			compare("pair_ready", US_WIDTH'(want.pair), US_WIDTH'(got.pair));
			compare("x_interval_us", want.x_iv, got.x_iv);
			compare("y_interval_us", want.y_iv, got.y_iv);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0]  paddr = '0;
	logic [DATA_WIDTH-1:0]  pwdata = '0;
	logic [DATA_WIDTH-1:0]  prdata;
	logic                   pready;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [15:0]            rise_time = '0;
	logic [15:0]            fall_time = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [US_WIDTH-1:0]    pulse_width_us;
	logic [COUNT_WIDTH-1:0] sync_count;
	logic [AXIS_WIDTH-1:0]  sweep_axis;
	logic                   pair_ready;
	logic [US_WIDTH-1:0]    x_interval_us;
	logic [US_WIDTH-1:0]    y_interval_us;

	pulse_decode_scoreboard sb;
	bit src_idle_on = 1'b0;
	bit sink_stall_on = 1'b0;
	int stall_left = 0;
	int items_sent = 0;

	sync_sweep_pulse_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rise_time      (rise_time),
		.fall_time      (fall_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pulse_width_us (pulse_width_us),
		.sync_count     (sync_count),
		.sweep_axis     (sweep_axis),
		.pair_ready     (pair_ready),
		.x_interval_us  (x_interval_us),
		.y_interval_us  (y_interval_us)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: back-pressure comes in bursts of random length while enabled.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_stall_on && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pulse_fields_t got;
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				sb.write_reg(paddr[ADDR_WIDTH-1:2], pwdata);
			if (in_valid && in_ready)
				sb.note_pulse(rise_time, fall_time);
			if (out_valid && out_ready) begin
				got.width = pulse_width_us;
				got.count = sync_count;
				got.axis  = sweep_axis;
				got.pair  = pair_ready;
				got.x_iv  = x_interval_us;
				got.y_iv  = y_interval_us;
				sb.check_result(got);
			end
		end
	end

	task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [DATA_WIDTH-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_setting(input int upt, input int smin, input int lo, input int hi,
			input int lim, input int xc, input int yc);
		write_reg(REG_US_PER_TICK, upt);
		write_reg(REG_SYNC_WIDTH_MIN, smin);
		write_reg(REG_SWEEP_WIDTH_LOW, lo);
		write_reg(REG_SWEEP_WIDTH_HIGH, hi);
		write_reg(REG_SYNC_COUNT_LIMIT, lim);
		write_reg(REG_X_SYNC_COUNT, xc);
		write_reg(REG_Y_SYNC_COUNT, yc);
	endtask

	// Stop sending and wait until every pending result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic push_pulse(input logic [15:0] rise, input logic [15:0] fall);
		in_valid  <= 1'b1;
		rise_time <= rise;
		fall_time <= fall;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (src_idle_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	function automatic int sync_ticks();
		int upt;
		int lo;
		upt = int'(sb.cfg.us_per_tick);
		if (upt == 0)
			return $urandom_range(0, 65535);
		lo = sb.cfg.sync_width_min / upt + 1;
		if (lo > 65535)
			return 65535;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(65535, lo);
		return $urandom_range((lo + 8 > 65535) ? 65535 : lo + 8, lo);
	endfunction

	function automatic int sweep_ticks();
		int upt;
		int lo;
		int hi;
		upt = int'(sb.cfg.us_per_tick);
		if (upt == 0 || sb.cfg.sweep_width_high == 0)
			return $urandom_range(0, 15);
		lo = sb.cfg.sweep_width_low / upt + 1;
		hi = (sb.cfg.sweep_width_high - 1) / upt;
		if (hi > 65535)
			hi = 65535;
		if (lo > hi)
			return $urandom_range(0, 15);
		return $urandom_range(hi, lo);
	endfunction

	task automatic push_noise();
		logic [15:0] rise;
		rise = 16'($urandom);
		if ($urandom_range(0, 1) == 0)
			push_pulse(rise, 16'($urandom));
		else
			push_pulse(rise, rise + 16'($urandom_range(0, 40)));
	endtask

	// Mostly well-formed frames: a run of sync pulses followed by a sweep.
	task automatic send_frame();
		int target;
		int k;
		logic [15:0] rise;
		if ($urandom_range(0, 3) == 0) begin
			push_noise();
		end else begin
			case ($urandom_range(0, 2))
				0: target = int'(sb.cfg.x_sync_count);
				1: target = int'(sb.cfg.y_sync_count);
				default: target = $urandom_range(0, 15);
			endcase
			for (k = 0; k < target; k++) begin
				if ($urandom_range(0, 11) == 0) begin
					push_noise();
				end else begin
					rise = 16'($urandom);
					push_pulse(rise, rise + 16'(sync_ticks()));
				end
			end
			rise = 16'($urandom);
			push_pulse(rise, rise + 16'(sweep_ticks()));
		end
	endtask

	task automatic run_phase(input int budget, input bit may_idle);
		int start;
		bit drained;
		start = items_sent;
		drained = 1'b0;
		if (!may_idle) begin
			src_idle_on = 1'b0;
			sink_stall_on = 1'b0;
		end
		while (items_sent - start < budget) begin
			if (may_idle && $urandom_range(0, 15) == 0) begin
				src_idle_on = $urandom_range(0, 3) != 0;
				sink_stall_on = $urandom_range(0, 3) != 0;
			end
			if (!drained && items_sent - start >= budget / 2) begin
				settle();
				drained = 1'b1;
			end
			send_frame();
		end
		settle();
	endtask

	initial begin
		int k;
		int lo;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed pulses under the reset settings.
		push_pulse(16'h0000, 16'h0000);
		push_pulse(16'hFFFF, 16'hFFFF);
		push_pulse(16'h0000, 16'hFFFF);
		push_pulse(16'hFFFF, 16'h0000);
		push_pulse(16'h0001, 16'h0000);
		push_pulse(16'hAAAA, 16'hAAAA + 16'd18);
		push_pulse(16'h5555, 16'h5555 + 16'd17);
		push_pulse(16'h1234, 16'h1234 + 16'd18);
		push_pulse(16'h1300, 16'h1305);
		push_pulse(16'h1300, 16'h1304);
		push_pulse(16'h7FFF, 16'h8000);
		// Run the sync count past its limit so that it is cleared.
		for (k = 0; k < 12; k++)
			push_pulse(16'h8000 >> k, (16'h8000 >> k) + 16'd20 + 16'(k));
		push_pulse(16'hF00F, 16'hF00F + 16'd2);
		settle();

		apply_setting(RST_US_PER_TICK, RST_SYNC_WIDTH_MIN, RST_SWEEP_WIDTH_LOW,
			RST_SWEEP_WIDTH_HIGH, RST_SYNC_COUNT_LIMIT, RST_X_SYNC_COUNT, RST_Y_SYNC_COUNT);
		run_phase(400, 1'b1);

		// Every pulse of nonzero width is both sync and sweep, and both axes share one count.
		apply_setting(1, 0, 0, 983025, 14, 2, 2);
		run_phase(300, 1'b1);

		// Zero scale.
		apply_setting(0, 0, 0, 983025, 0, 0, 0);
		run_phase(60, 1'b1);

		// Limit at the top of the counter so that it wraps from 15 to 0.
		apply_setting(2, 100, 10, 60, 15, 15, 0);
		run_phase(300, 1'b1);

		// Bounds at their extremes: nothing is sync and nothing is sweep.
		apply_setting(15, 983025, 983025, 0, 0, 15, 15);
		run_phase(60, 1'b1);

		for (k = 0; k < 2; k++) begin
			lo = $urandom_range(0, 300);
			apply_setting($urandom_range(1, 15), $urandom_range(0, 2000), lo,
				lo + $urandom_range(1, 1000), $urandom_range(0, 14),
				$urandom_range(0, 15), $urandom_range(0, 15));
			run_phase(300, 1'b1);
		end

		apply_setting(RST_US_PER_TICK, RST_SYNC_WIDTH_MIN, RST_SWEEP_WIDTH_LOW,
			RST_SWEEP_WIDTH_HIGH, RST_SYNC_COUNT_LIMIT, RST_X_SYNC_COUNT, RST_Y_SYNC_COUNT);
		run_phase(300, 1'b0);

		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("sync_sweep_pulse_decoder_unit: match");
		else
			$display("sync_sweep_pulse_decoder_unit: mismatch");
		$finish;
	end

	initial begin
		#5000000;
		$display("sync_sweep_pulse_decoder_unit: mismatch");
		$finish;
	end

endmodule
